### hw/rtl/cswb_pkg.sv
// ----------------------------------------------------------------------------
// cswb_pkg
// Shared types and constants for the coalescing staged write buffer.
// ----------------------------------------------------------------------------
package cswb_pkg;

	localparam int MAX_PENDING_DEF   = 64;
	localparam int ADDRESS_WIDTH_DEF = 32;
	localparam int VALUE_WIDTH_DEF   = 32;

	localparam logic [1:0] MODE_STAGE   = 2'd0;
	localparam logic [1:0] MODE_APPLY   = 2'd1;
	localparam logic [1:0] MODE_DISCARD = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MATCH,
		ST_APPLY
	} state_t;

	typedef struct packed {
		logic load_req;
		logic stage;
		logic rd_start;
		logic apply_rd;
		logic resp_keep;
		logic resp_clear;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic rd_last;
	} status_t;

endpackage

### hw/rtl/cswb_ctrl.sv
// ----------------------------------------------------------------------------
// cswb_ctrl
// Controller: sequences stage, apply and discard transactions.
// ----------------------------------------------------------------------------
module cswb_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [1:0]        mode,
	input  cswb_pkg::status_t status,
	output cswb_pkg::cmd_t    cmd,
	output logic              busy
);
	import cswb_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		busy      = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (mode)
						MODE_STAGE: begin
							cmd.load_req = 1'b1;
							state_nxt    = ST_MATCH;
						end
						MODE_APPLY: begin
							if (status.empty) begin
								cmd.resp_clear = 1'b1;
							end else begin
								cmd.rd_start = 1'b1;
								state_nxt    = ST_APPLY;
							end
						end
						MODE_DISCARD: begin
							cmd.resp_clear = 1'b1;
						end
						default: begin
							cmd.resp_keep = 1'b1;
						end
					endcase
				end
			end
			ST_MATCH: begin
				cmd.stage = 1'b1;
				state_nxt = ST_IDLE;
			end
			ST_APPLY: begin
				cmd.apply_rd = 1'b1;
				if (status.rd_last) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

endmodule

### hw/rtl/cswb_dp.sv
// ----------------------------------------------------------------------------
// cswb_dp
// Datapath: address match lanes, entry memories, fill count, result registers.
// ----------------------------------------------------------------------------
module cswb_dp #(
	parameter int MAX_PENDING   = cswb_pkg::MAX_PENDING_DEF,
	parameter int ADDRESS_WIDTH = cswb_pkg::ADDRESS_WIDTH_DEF,
	parameter int VALUE_WIDTH   = cswb_pkg::VALUE_WIDTH_DEF,
	parameter int CNT_W         = $clog2(MAX_PENDING + 1)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cswb_pkg::cmd_t           cmd,
	output cswb_pkg::status_t        status,
	input  logic [ADDRESS_WIDTH-1:0] target_address,
	input  logic [VALUE_WIDTH-1:0]   new_value,
	output logic                     done,
	output logic                     accepted,
	output logic                     write_valid,
	output logic [ADDRESS_WIDTH-1:0] write_address,
	output logic [VALUE_WIDTH-1:0]   write_value,
	output logic [CNT_W-1:0]         applied_count,
	output logic [CNT_W-1:0]         pending_count,
	output logic                     last
);
	import cswb_pkg::*;

	localparam int IDX_W = (MAX_PENDING > 1) ? $clog2(MAX_PENDING) : 1;

	logic [ADDRESS_WIDTH-1:0] req_addr_q;
	logic [VALUE_WIDTH-1:0]   req_val_q;
	logic [CNT_W-1:0]         count_q;
	logic [IDX_W-1:0]         rd_idx_q;

	logic [ADDRESS_WIDTH-1:0] cam_q [MAX_PENDING];
	logic [ADDRESS_WIDTH-1:0] addr_mem [MAX_PENDING];
	logic [VALUE_WIDTH-1:0]   val_mem [MAX_PENDING];
	logic [ADDRESS_WIDTH-1:0] rd_addr_q;
	logic [VALUE_WIDTH-1:0]   rd_val_q;

	logic                     done_q;
	logic                     accepted_q;
	logic                     wv_q;
	logic [CNT_W-1:0]         applied_q;
	logic [CNT_W-1:0]         pending_q;
	logic                     last_q;

	logic [MAX_PENDING-1:0]   hit_vec;
	logic [IDX_W-1:0]         hit_idx;
	logic                     hit_any;
	logic                     acc;
	logic                     append;
	logic [IDX_W-1:0]         wr_idx;
	logic [CNT_W-1:0]         count_after;
	logic                     rd_last;

	always_comb begin
		hit_idx = '0;
		for (int i = 0; i < MAX_PENDING; i++) begin
			hit_vec[i] = (CNT_W'(i) < count_q) && (cam_q[i] == req_addr_q);
			if (hit_vec[i]) begin
				hit_idx = hit_idx | IDX_W'(i);
			end
		end
		hit_any     = |hit_vec;
		acc         = (req_addr_q != '0) && (hit_any || (count_q != CNT_W'(MAX_PENDING)));
		append      = acc && !hit_any;
		wr_idx      = hit_any ? hit_idx : count_q[IDX_W-1:0];
		count_after = append ? count_q + CNT_W'(1) : count_q;
	end

	assign rd_last        = (CNT_W'(rd_idx_q) == count_q - CNT_W'(1));
	assign status.empty   = (count_q == '0);
	assign status.rd_last = rd_last;

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_addr_q <= target_address;
			req_val_q  <= new_value;
		end
		if (cmd.stage && append) begin
			cam_q[wr_idx] <= req_addr_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.stage && acc) begin
			addr_mem[wr_idx] <= req_addr_q;
			val_mem[wr_idx]  <= req_val_q;
		end
		if (cmd.apply_rd) begin
			rd_addr_q <= addr_mem[rd_idx_q];
			rd_val_q  <= val_mem[rd_idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			rd_idx_q <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= cmd.stage | cmd.apply_rd | cmd.resp_keep | cmd.resp_clear;
			if (cmd.rd_start) begin
				rd_idx_q <= '0;
			end else if (cmd.apply_rd) begin
				rd_idx_q <= rd_idx_q + IDX_W'(1);
			end
			if (cmd.stage) begin
				count_q <= count_after;
			end else if (cmd.resp_clear || (cmd.apply_rd && rd_last)) begin
				count_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.stage) begin
			accepted_q <= acc;
			wv_q       <= 1'b0;
			applied_q  <= '0;
			pending_q  <= count_after;
			last_q     <= 1'b1;
		end else if (cmd.apply_rd) begin
			accepted_q <= 1'b0;
			wv_q       <= 1'b1;
			applied_q  <= count_q;
			pending_q  <= '0;
			last_q     <= rd_last;
		end else if (cmd.resp_keep || cmd.resp_clear) begin
			accepted_q <= 1'b0;
			wv_q       <= 1'b0;
			applied_q  <= '0;
			pending_q  <= cmd.resp_keep ? count_q : '0;
			last_q     <= 1'b1;
		end
	end

	assign done          = done_q;
	assign accepted      = accepted_q;
	assign write_valid   = wv_q;
	assign write_address = wv_q ? rd_addr_q : '0;
	assign write_value   = wv_q ? rd_val_q : '0;
	assign applied_count = applied_q;
	assign pending_count = pending_q;
	assign last          = last_q;

endmodule

### hw/rtl/coalescing_staged_write_buffer_unit.sv
// ----------------------------------------------------------------------------
// coalescing_staged_write_buffer_unit
// Table of pending writes, coalesced by address, committed or dropped whole.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction is taken on a clock edge with start high and busy low;
//   mode selects stage (0), apply (1), discard (2); mode 3 does nothing.
//   Each result is shown for one cycle with done high and cannot be held off.
//   Stage: busy in the match state (address match and table write); the result
//     is registered from the match state, and the next transaction waits for the
//     match over the address lanes to finish.
//   Apply of n entries: busy until the last entry is read, one result per
//     cycle from the entry memory read port, last marked by last. An empty
//     apply gives one result.
//   Discard, empty apply, mode 3: result in the cycle after acceptance, and the
//     next transaction may follow in the next cycle.
//   A new transaction may be taken while the final result is still shown.
//   Reset empties the table; entry storage is not cleared.
// ----------------------------------------------------------------------------
module coalescing_staged_write_buffer_unit #(
	parameter int MAX_PENDING   = cswb_pkg::MAX_PENDING_DEF,
	parameter int ADDRESS_WIDTH = cswb_pkg::ADDRESS_WIDTH_DEF,
	parameter int VALUE_WIDTH   = cswb_pkg::VALUE_WIDTH_DEF,
	parameter int CNT_W         = $clog2(MAX_PENDING + 1)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [1:0]               mode,
	input  logic [ADDRESS_WIDTH-1:0] target_address,
	input  logic [VALUE_WIDTH-1:0]   new_value,
	output logic                     done,
	output logic                     accepted,
	output logic                     write_valid,
	output logic [ADDRESS_WIDTH-1:0] write_address,
	output logic [VALUE_WIDTH-1:0]   write_value,
	output logic [CNT_W-1:0]         applied_count,
	output logic [CNT_W-1:0]         pending_count,
	output logic                     last
);
	import cswb_pkg::*;

	cmd_t    cmd;
	status_t status;

	cswb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mode   (mode),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	cswb_dp #(
		.MAX_PENDING   (MAX_PENDING),
		.ADDRESS_WIDTH (ADDRESS_WIDTH),
		.VALUE_WIDTH   (VALUE_WIDTH),
		.CNT_W         (CNT_W)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.target_address (target_address),
		.new_value      (new_value),
		.done           (done),
		.accepted       (accepted),
		.write_valid    (write_valid),
		.write_address  (write_address),
		.write_value    (write_value),
		.applied_count  (applied_count),
		.pending_count  (pending_count),
		.last           (last)
	);

endmodule

### verif/coalescing_staged_write_buffer_unit_tb.sv
// ----------------------------------------------------------------------------
// coalescing_staged_write_buffer_unit_tb
// Drives stage, apply, discard and no-op transactions into the write buffer,
// predicts the table contents and every committed write in staging order,
// and checks each strobed result field by field against the prediction.
// ----------------------------------------------------------------------------
module coalescing_staged_write_buffer_unit_tb;
	import cswb_pkg::*;

	localparam int AW          = ADDRESS_WIDTH_DEF;
	localparam int VW          = VALUE_WIDTH_DEF;
	localparam int DEPTH       = MAX_PENDING_DEF;
	localparam int CW          = $clog2(MAX_PENDING_DEF + 1);
	localparam logic [1:0] MODE_NOP = 2'd3;
	localparam int ITEM_GOAL   = 370;
	localparam int QUIET_TAIL  = 60;

	typedef struct packed {
		logic          accepted;
		logic          write_valid;
		logic [AW-1:0] write_address;
		logic [VW-1:0] write_value;
		logic [CW-1:0] applied_count;
		logic [CW-1:0] pending_count;
		logic          last;
	} buf_result_t;

	class write_buffer_scoreboard;
		logic [AW-1:0] pend_addr [DEPTH];
		logic [VW-1:0] pend_val [DEPTH];
		int unsigned   pend_cnt;
		buf_result_t   expected_q[$];
		int unsigned   errors;

		function new();
			pend_cnt = 0;
			errors   = 0;
		endfunction

		function void push_result(logic acc, logic wv, logic [AW-1:0] wa, logic [VW-1:0] wd,
				int unsigned applied, int unsigned pend, logic lst);
			buf_result_t r;
			r.accepted      = acc;
			r.write_valid   = wv;
			r.write_address = wa;
			r.write_value   = wd;
			r.applied_count = CW'(applied);
			r.pending_count = CW'(pend);
			r.last          = lst;
			expected_q.push_back(r);
		endfunction

		function void note_item(logic [1:0] op, logic [AW-1:0] a, logic [VW-1:0] v);
			logic        acc;
			int unsigned n;
			acc = 1'b0;
			n   = pend_cnt;
			case (op)
				MODE_STAGE: begin
					if (a != '0) begin
						for (int i = 0; i < n; i++) begin
							if (!acc && pend_addr[i] == a) begin
								pend_val[i] = v;
								acc = 1'b1;
							end
						end
						if (!acc && n < DEPTH) begin
							pend_addr[n] = a;
							pend_val[n]  = v;
							pend_cnt     = n + 1;
							acc          = 1'b1;
						end
					end
					push_result(acc, 1'b0, '0, '0, 0, pend_cnt, 1'b1);
				end
				MODE_APPLY: begin
					pend_cnt = 0;
					if (n == 0)
						push_result(1'b0, 1'b0, '0, '0, 0, 0, 1'b1);
					for (int i = 0; i < n; i++)
						push_result(1'b0, 1'b1, pend_addr[i], pend_val[i], n, 0, i == n - 1);
				end
				MODE_DISCARD: begin
					pend_cnt = 0;
					push_result(1'b0, 1'b0, '0, '0, 0, 0, 1'b1);
				end
				default: push_result(1'b0, 1'b0, '0, '0, 0, pend_cnt, 1'b1);
			endcase
		endfunction

		function void field_check(string name, logic [63:0] exp_v, logic [63:0] act_v);
			if (exp_v !== act_v) begin
				$display("%0t: %s mismatch: expected %0h actual %0h", $time, name, exp_v, act_v);
				errors++;
			end
		endfunction

		function void check_result(buf_result_t got);
			buf_result_t exp_r;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result: expected none actual %h", $time, got);
				errors++;
				return;
			end
			exp_r = expected_q.pop_front();
			field_check("accepted", 64'(exp_r.accepted), 64'(got.accepted));
			field_check("write_valid", 64'(exp_r.write_valid), 64'(got.write_valid));
			field_check("write_address", 64'(exp_r.write_address), 64'(got.write_address));
			field_check("write_value", 64'(exp_r.write_value), 64'(got.write_value));
			field_check("applied_count", 64'(exp_r.applied_count), 64'(got.applied_count));
			field_check("pending_count", 64'(exp_r.pending_count), 64'(got.pending_count));
			field_check("last", 64'(exp_r.last), 64'(got.last));
		endfunction
	endclass

	logic          clk;
	logic          arst_n;
	logic          start;
	logic          busy;
	logic [1:0]    mode;
	logic [AW-1:0] target_address;
	logic [VW-1:0] new_value;
	logic          done;
	logic          accepted;
	logic          write_valid;
	logic [AW-1:0] write_address;
	logic [VW-1:0] write_value;
	logic [CW-1:0] applied_count;
	logic [CW-1:0] pending_count;
	logic          last;

	write_buffer_scoreboard sb;
	int unsigned            items_sent;

	coalescing_staged_write_buffer_unit dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.mode           (mode),
		.target_address (target_address),
		.new_value      (new_value),
		.done           (done),
		.accepted       (accepted),
		.write_valid    (write_valid),
		.write_address  (write_address),
		.write_value    (write_value),
		.applied_count  (applied_count),
		.pending_count  (pending_count),
		.last           (last)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	always @(posedge clk) begin
		buf_result_t r;
		if (arst_n && done) begin
			r.accepted      = accepted;
			r.write_valid   = write_valid;
			r.write_address = write_address;
			r.write_value   = write_value;
			r.applied_count = applied_count;
			r.pending_count = pending_count;
			r.last          = last;
			sb.check_result(r);
		end
	end

	task automatic idle_burst(int unsigned n);
		start          = 1'b0;
		mode           = 2'($urandom);
		target_address = AW'($urandom);
		new_value      = VW'($urandom);
		repeat (n) @(negedge clk);
	endtask

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_item(logic [1:0] op, logic [AW-1:0] a, logic [VW-1:0] v);
		if (items_sent < ITEM_GOAL - QUIET_TAIL && $urandom_range(0, 3) == 0)
			idle_burst($urandom_range(1, 4));
		start          = 1'b1;
		mode           = op;
		target_address = a;
		new_value      = v;
		do
			@(posedge clk);
		while (busy);
		sb.note_item(op, a, v);
		items_sent++;
		@(negedge clk);
	endtask

	function automatic logic [VW-1:0] pick_value();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		return VW'($urandom);
	endfunction

	function automatic logic [AW-1:0] pick_address();
		int unsigned r;
		r = $urandom_range(0, 19);
		if (r < 2)
			return '0;
		if (r < 11)
			return AW'($urandom_range(1, 8));
		return AW'($urandom);
	endfunction

	// distinct addresses up to six past the table size, then coalescing into a full table
	task automatic fill_batch();
		logic [AW-1:0] base;
		int unsigned   n;
		base = AW'($urandom_range(1, 32'hffff_0000));
		n    = $urandom_range(DEPTH, DEPTH + 6);
		for (int i = 0; i < n; i++)
			send_item(MODE_STAGE, base + AW'(i * 7), pick_value());
		repeat ($urandom_range(1, 3))
			send_item(MODE_STAGE, base + AW'($urandom_range(0, DEPTH - 1) * 7), pick_value());
		send_item(MODE_APPLY, AW'($urandom), VW'($urandom));
	endtask

	task automatic mixed_batch();
		int unsigned n;
		int unsigned r;
		n = $urandom_range(0, 12);
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 39);
			if (r == 0)
				send_item(MODE_NOP, AW'($urandom), VW'($urandom));
			else if (r == 1)
				send_item(MODE_APPLY, AW'($urandom), VW'($urandom));
			else
				send_item(MODE_STAGE, pick_address(), pick_value());
		end
		r = $urandom_range(0, 19);
		if (r < 15)
			send_item(MODE_APPLY, AW'($urandom), VW'($urandom));
		else if (r < 19)
			send_item(MODE_DISCARD, AW'($urandom), VW'($urandom));
		else
			send_item(MODE_NOP, AW'($urandom), VW'($urandom));
	endtask

	initial begin
		sb             = new();
		items_sent     = 0;
		arst_n         = 1'b0;
		start          = 1'b0;
		mode           = MODE_STAGE;
		target_address = '0;
		new_value      = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_item(MODE_APPLY, '0, '0);
		send_item(MODE_DISCARD, '1, '1);
		send_item(MODE_NOP, '1, '0);
		send_item(MODE_STAGE, '0, '1);
		send_item(MODE_STAGE, '1, '0);
		send_item(MODE_STAGE, AW'(1), '1);
		send_item(MODE_STAGE, AW'(32'h8000_0000), VW'(32'h1234_5678));
		send_item(MODE_STAGE, AW'(1), VW'(32'ha5a5_a5a5));
		send_item(MODE_NOP, AW'(1), '1);
		send_item(MODE_APPLY, '0, '0);
		send_item(MODE_STAGE, AW'(32'h10), VW'(1));
		send_item(MODE_STAGE, AW'(32'h20), VW'(2));
		send_item(MODE_DISCARD, '0, '0);
		send_item(MODE_APPLY, '1, '1);
		send_item(MODE_STAGE, AW'(32'h55), VW'(32'h55));
		send_item(MODE_APPLY, AW'(32'h55), '0);

		fill_batch();
		while (items_sent < ITEM_GOAL) begin
			if ($urandom_range(0, 7) == 0 && items_sent < ITEM_GOAL - DEPTH - 10)
				fill_batch();
			else
				mixed_batch();
		end
		start = 1'b0;

		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.expected_q.size() == 0)
			$display("coalescing_staged_write_buffer_unit_tb: PASS");
		else
			$display("coalescing_staged_write_buffer_unit_tb: FAIL");
		$finish;
	end

	initial begin
		#3000000;
		$display("timeout: %0d results still expected", sb.expected_q.size());
		$display("coalescing_staged_write_buffer_unit_tb: FAIL");
		$finish;
	end

endmodule
